// ===== rtl/core/hermite_sample_interpolator_core_macros.svh =====
// Assertion macros for the hermite sample interpolator core.
// Expects clk_i and rst_ni in the scope of use.
`ifndef HERMITE_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH
`define HERMITE_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define HSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hsi_pkg.sv =====
// Shared types, codes and constants of the hermite sample interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsi_pkg;

  localparam int TimeW  = 32;
  localparam int ValW   = 32;
  localparam int Hq     = 30;
  localparam int MulW   = 34;
  localparam int Div1Steps = 30;
  localparam int Div2Steps = 34;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LOW    = 3'd1,
    ST_HIGH   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_REJECT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [TimeW-1:0]       time_value;
    logic signed [ValW-1:0] position_value;
    logic signed [ValW-1:0] velocity_value;
  } in_req_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_position;
    logic signed [ValW-1:0] out_velocity;
    logic [2:0]             status;
  } out_rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_RES_ZERO, OP_APP_WRITE, OP_RD_FIRST, OP_RD_LAST,
    OP_RES_RD, OP_SRCH_INIT, OP_SRCH_RD, OP_SRCH_UPD, OP_RD_LO, OP_LAT1, OP_LAT2,
    OP_DIV1, OP_MUL_SS, OP_MUL_S2S, OP_COEF, OP_MUL_H01, OP_MUL_H10, OP_MUL_H11,
    OP_ACC_T, OP_MUL_D, OP_MUL_AV1, OP_MUL_BV2, OP_MUL_G, OP_DIV2_INIT, OP_DIV2,
    OP_FINAL, OP_PUSH
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_APP_CHK, S_Q_CHK0, S_Q_CHKL, S_SRCH, S_SRCH_CMP, S_LAT1,
    S_LAT2, S_DIV1, S_MUL_SS, S_MUL_S2S, S_COEF, S_MUL_H01, S_MUL_H10, S_MUL_H11,
    S_ACC_T, S_MUL_D, S_MUL_AV1, S_MUL_BV2, S_MUL_G, S_DIV2_INIT, S_DIV2, S_FINAL,
    S_PUSH
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       cnt_zero;
    logic       cnt_full;
    logic       t_lt_rd;
    logic       t_gt_rd;
    logic       lo_lt_hi;
    logic       div1_last;
    logic       div2_last;
    logic       out_free;
  } sts_t;

  function automatic logic signed [ValW-1:0] sat_val(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat_val = hi[ValW-1:0];
    end else if (x < lo) begin
      sat_val = lo[ValW-1:0];
    end else begin
      sat_val = x[ValW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hermite_sample_interpolator_core.sv =====
// Hermite sample interpolator: a table of time-ordered samples that takes one
// request at a time (clear, append or query) and gives one result per request.
// An interpolating query runs a binary search through the table's one read port,
// a 30-step fraction divider, nine products on one shared 34x34 multiplier and a
// 34-step velocity divider. A finished result waits until the output is free.
// A new request is taken while the previous result still waits at the output.
`timescale 1ns / 1ps
`default_nettype none
module hermite_sample_interpolator_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hsi_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hsi_pkg::out_rsp_t      out_rsp_o
);
  import hsi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hsi_ctrl.sv =====
// Sequencer of the hermite sample interpolator.
// Depends on hsi_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none
module hsi_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire hsi_pkg::sts_t sts_i,
  output hsi_pkg::cmd_t     cmd_o
);
  import hsi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (sts_i.action)
          ACT_APPEND: state_d = (sts_i.cnt_full || sts_i.cnt_zero) ? S_PUSH : S_APP_CHK;
          ACT_QUERY:  state_d = sts_i.cnt_zero ? S_PUSH : S_Q_CHK0;
          default:    state_d = S_PUSH;
        endcase
      end
      S_APP_CHK:   state_d = S_PUSH;
      S_Q_CHK0:    state_d = sts_i.t_lt_rd ? S_PUSH : S_Q_CHKL;
      S_Q_CHKL:    state_d = sts_i.t_lt_rd ? S_SRCH : S_PUSH;
      S_SRCH:      state_d = sts_i.lo_lt_hi ? S_SRCH_CMP : S_LAT1;
      S_SRCH_CMP:  state_d = S_SRCH;
      S_LAT1:      state_d = S_LAT2;
      S_LAT2:      state_d = S_DIV1;
      S_DIV1:      if (sts_i.div1_last) state_d = S_MUL_SS;
      S_MUL_SS:    state_d = S_MUL_S2S;
      S_MUL_S2S:   state_d = S_COEF;
      S_COEF:      state_d = S_MUL_H01;
      S_MUL_H01:   state_d = S_MUL_H10;
      S_MUL_H10:   state_d = S_MUL_H11;
      S_MUL_H11:   state_d = S_ACC_T;
      S_ACC_T:     state_d = S_MUL_D;
      S_MUL_D:     state_d = S_MUL_AV1;
      S_MUL_AV1:   state_d = S_MUL_BV2;
      S_MUL_BV2:   state_d = S_MUL_G;
      S_MUL_G:     state_d = S_DIV2_INIT;
      S_DIV2_INIT: state_d = S_DIV2;
      S_DIV2:      if (sts_i.div2_last) state_d = S_FINAL;
      S_FINAL:     state_d = S_PUSH;
      S_PUSH:      if (sts_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.st   = ST_OK;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH: begin
        case (sts_i.action)
          ACT_CLEAR: cmd_o.op = OP_CLEAR;
          ACT_APPEND: begin
            if (sts_i.cnt_full) begin
              cmd_o.op = OP_RES_ZERO;
              cmd_o.st = ST_REJECT;
            end else if (sts_i.cnt_zero) begin
              cmd_o.op = OP_APP_WRITE;
            end else begin
              cmd_o.op = OP_RD_LAST;
            end
          end
          ACT_QUERY: begin
            if (sts_i.cnt_zero) begin
              cmd_o.op = OP_RES_ZERO;
              cmd_o.st = ST_EMPTY;
            end else begin
              cmd_o.op = OP_RD_FIRST;
            end
          end
          default: cmd_o.op = OP_RES_ZERO;
        endcase
      end
      S_APP_CHK: begin
        if (sts_i.t_gt_rd) begin
          cmd_o.op = OP_APP_WRITE;
        end else begin
          cmd_o.op = OP_RES_ZERO;
          cmd_o.st = ST_REJECT;
        end
      end
      S_Q_CHK0: begin
        if (sts_i.t_lt_rd) begin
          cmd_o.op = OP_RES_RD;
          cmd_o.st = ST_LOW;
        end else begin
          cmd_o.op = OP_RD_LAST;
        end
      end
      S_Q_CHKL: begin
        if (sts_i.t_lt_rd) begin
          cmd_o.op = OP_SRCH_INIT;
        end else begin
          cmd_o.op = OP_RES_RD;
          cmd_o.st = sts_i.t_gt_rd ? ST_HIGH : ST_OK;
        end
      end
      S_SRCH:      cmd_o.op = sts_i.lo_lt_hi ? OP_SRCH_RD : OP_RD_LO;
      S_SRCH_CMP:  cmd_o.op = OP_SRCH_UPD;
      S_LAT1:      cmd_o.op = OP_LAT1;
      S_LAT2:      cmd_o.op = OP_LAT2;
      S_DIV1:      cmd_o.op = OP_DIV1;
      S_MUL_SS:    cmd_o.op = OP_MUL_SS;
      S_MUL_S2S:   cmd_o.op = OP_MUL_S2S;
      S_COEF:      cmd_o.op = OP_COEF;
      S_MUL_H01:   cmd_o.op = OP_MUL_H01;
      S_MUL_H10:   cmd_o.op = OP_MUL_H10;
      S_MUL_H11:   cmd_o.op = OP_MUL_H11;
      S_ACC_T:     cmd_o.op = OP_ACC_T;
      S_MUL_D:     cmd_o.op = OP_MUL_D;
      S_MUL_AV1:   cmd_o.op = OP_MUL_AV1;
      S_MUL_BV2:   cmd_o.op = OP_MUL_BV2;
      S_MUL_G:     cmd_o.op = OP_MUL_G;
      S_DIV2_INIT: cmd_o.op = OP_DIV2_INIT;
      S_DIV2:      cmd_o.op = OP_DIV2;
      S_FINAL:     cmd_o.op = OP_FINAL;
      S_PUSH:      if (sts_i.out_free) cmd_o.op = OP_PUSH;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hsi_datapath.sv =====
// Datapath of the hermite sample interpolator: sample table, search
// registers, shared multiplier, two serial dividers, output register.
// Depends on hsi_pkg and the core macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "hermite_sample_interpolator_core_macros.svh"
module hsi_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hsi_pkg::in_req_t in_req_i,
  input  wire hsi_pkg::cmd_t    cmd_i,
  output hsi_pkg::sts_t         sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hsi_pkg::out_rsp_t     out_rsp_o
);
  import hsi_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  logic [TimeW-1:0]       mem_t [TABLE_DEPTH];
  logic signed [ValW-1:0] mem_p [TABLE_DEPTH];
  logic signed [ValW-1:0] mem_v [TABLE_DEPTH];

  logic [1:0]             act_q;
  logic [TimeW-1:0]       t_q;
  logic signed [ValW-1:0] pin_q, vin_q;
  logic [CntW-1:0]        cnt_q;
  logic [IdxW-1:0]        lo_q, hi_q, mid_q, mid_d, rd_addr;
  logic [IdxW:0]          span;
  logic [CntW-1:0]        cnt_m1;
  logic [TimeW-1:0]       rd_t_q, t1_q, t2_q, dur, u;
  logic signed [ValW-1:0] rd_p_q, rd_v_q, p1_q, p2_q, v1_q, v2_q;
  logic                   wr_en;
  logic [5:0]             it_q;
  logic [TimeW:0]         rem1_q;
  logic [TimeW+1:0]       r1;
  logic [Div1Steps-1:0]   q1_q;
  logic [TimeW-1:0]       rem2_q;
  logic [TimeW:0]         r2;
  logic [Div2Steps-1:0]   a2_q;
  logic                   neg_q;
  logic signed [MulW-1:0] s_q, s2_q, h01_q, h10_q, h11_q, g_q, ca_q, cb_q;
  logic signed [MulW-1:0] s3_d, mul_a, mul_b, dp, dd, acct_sh;
  logic signed [2*MulW-1:0] mul_full;
  logic signed [63:0]     prod_q, prod_sh, accp_q, acct_q, accv_q, absn, sumv, qext;
  logic signed [Div2Steps+1:0] qs;
  out_rsp_t               res_q, out_q;
  logic                   out_valid_q;

  assign cnt_m1  = cnt_q - CntW'(1);
  assign span    = {1'b0, hi_q} - {1'b0, lo_q} + (IdxW+1)'(1);
  assign mid_d   = lo_q + span[IdxW:1];
  assign dur     = t2_q - t1_q;
  assign u       = t_q - t1_q;
  assign dp      = MulW'(p2_q) - MulW'(p1_q);
  assign dd      = MulW'({1'b0, dur});
  assign prod_sh = prod_q >>> Hq;
  assign acct_sh = MulW'(acct_q >>> Hq);
  assign s3_d    = prod_sh[MulW-1:0];
  assign wr_en   = (cmd_i.op == OP_APP_WRITE);
  assign r1      = {rem1_q, 1'b0};
  assign r2      = {rem2_q, a2_q[Div2Steps-1]};
  assign absn    = prod_q[63] ? -prod_q : prod_q;
  assign sumv    = accv_q + prod_q;
  assign qs      = neg_q ? -$signed({2'b00, a2_q}) : $signed({2'b00, a2_q});
  assign qext    = 64'(qs);

  always_comb begin
    case (cmd_i.op)
      OP_RD_LAST: rd_addr = cnt_m1[IdxW-1:0];
      OP_RD_FIRST: rd_addr = '0;
      OP_SRCH_RD: rd_addr = mid_d;
      OP_LAT1: rd_addr = lo_q + IdxW'(1);
      default: rd_addr = lo_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_t[cnt_q[IdxW-1:0]] <= t_q;
      mem_p[cnt_q[IdxW-1:0]] <= pin_q;
      mem_v[cnt_q[IdxW-1:0]] <= vin_q;
    end
    rd_t_q <= mem_t[rd_addr];
    rd_p_q <= mem_p[rd_addr];
    rd_v_q <= mem_v[rd_addr];
  end

  always_comb begin
    case (cmd_i.op)
      OP_MUL_SS: begin
        mul_a = MulW'({1'b0, q1_q});
        mul_b = MulW'({1'b0, q1_q});
      end
      OP_MUL_S2S: begin
        mul_a = prod_sh[MulW-1:0];
        mul_b = s_q;
      end
      OP_MUL_H01: begin
        mul_a = h01_q;
        mul_b = dp;
      end
      OP_MUL_H10: begin
        mul_a = h10_q;
        mul_b = MulW'(v1_q);
      end
      OP_MUL_H11: begin
        mul_a = h11_q;
        mul_b = MulW'(v2_q);
      end
      OP_MUL_D: begin
        mul_a = dd;
        mul_b = acct_sh;
      end
      OP_MUL_AV1: begin
        mul_a = ca_q;
        mul_b = MulW'(v1_q);
      end
      OP_MUL_BV2: begin
        mul_a = cb_q;
        mul_b = MulW'(v2_q);
      end
      OP_MUL_G: begin
        mul_a = g_q;
        mul_b = dp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    case (cmd_i.op)
      OP_LOAD: begin
        act_q <= in_req_i.action;
        t_q   <= in_req_i.time_value;
        pin_q <= in_req_i.position_value;
        vin_q <= in_req_i.velocity_value;
      end
      OP_CLEAR, OP_RES_ZERO, OP_APP_WRITE: begin
        res_q.out_position <= '0;
        res_q.out_velocity <= '0;
        res_q.status       <= cmd_i.st;
      end
      OP_RES_RD: begin
        res_q.out_position <= rd_p_q;
        res_q.out_velocity <= rd_v_q;
        res_q.status       <= cmd_i.st;
      end
      OP_SRCH_RD: mid_q <= mid_d;
      OP_LAT1: begin
        t1_q <= rd_t_q;
        p1_q <= rd_p_q;
        v1_q <= rd_v_q;
      end
      OP_LAT2: begin
        t2_q   <= rd_t_q;
        p2_q   <= rd_p_q;
        v2_q   <= rd_v_q;
        rem1_q <= {1'b0, u};
        q1_q   <= '0;
      end
      OP_DIV1: begin
        if (r1 >= {2'b00, dur}) begin
          rem1_q <= (TimeW+1)'(r1 - {2'b00, dur});
          q1_q   <= {q1_q[Div1Steps-2:0], 1'b1};
        end else begin
          rem1_q <= r1[TimeW:0];
          q1_q   <= {q1_q[Div1Steps-2:0], 1'b0};
        end
      end
      OP_MUL_SS: s_q <= MulW'({1'b0, q1_q});
      OP_MUL_S2S: s2_q <= prod_sh[MulW-1:0];
      OP_COEF: begin
        h01_q <= s2_q + (s2_q <<< 1) - (s3_d <<< 1);
        h10_q <= s_q - (s2_q <<< 1) + s3_d;
        h11_q <= s3_d - s2_q;
        g_q   <= ((s_q - s2_q) <<< 2) + ((s_q - s2_q) <<< 1);
        ca_q  <= (MulW'(1) <<< Hq) - (s_q <<< 2) + s2_q + (s2_q <<< 1);
        cb_q  <= s2_q + (s2_q <<< 1) - (s_q <<< 1);
      end
      OP_MUL_H10: accp_q <= 64'(p1_q) + prod_sh;
      OP_MUL_H11: acct_q <= prod_q;
      OP_ACC_T: acct_q <= acct_q + prod_q;
      OP_MUL_AV1: accp_q <= accp_q + prod_q;
      OP_MUL_BV2: accv_q <= prod_q;
      OP_MUL_G: accv_q <= sumv >>> Hq;
      OP_DIV2_INIT: begin
        neg_q  <= prod_q[63];
        a2_q   <= absn[63:Hq];
        rem2_q <= '0;
      end
      OP_DIV2: begin
        if (r2 >= {1'b0, dur}) begin
          rem2_q <= TimeW'(r2 - {1'b0, dur});
          a2_q   <= {a2_q[Div2Steps-2:0], 1'b1};
        end else begin
          rem2_q <= r2[TimeW-1:0];
          a2_q   <= {a2_q[Div2Steps-2:0], 1'b0};
        end
      end
      OP_FINAL: begin
        res_q.out_position <= sat_val(accp_q);
        res_q.out_velocity <= sat_val(accv_q + qext);
        res_q.status       <= ST_OK;
      end
      OP_PUSH: out_q <= res_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        cnt_q <= '0;
      end else if (wr_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.op == OP_SRCH_INIT) begin
        lo_q <= '0;
        hi_q <= cnt_m1[IdxW-1:0];
      end else if (cmd_i.op == OP_SRCH_UPD) begin
        if (rd_t_q <= t_q) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q - IdxW'(1);
        end
      end
      if (cmd_i.op == OP_LAT2 || cmd_i.op == OP_DIV2_INIT) begin
        it_q <= '0;
      end else if (cmd_i.op == OP_DIV1 || cmd_i.op == OP_DIV2) begin
        it_q <= it_q + 6'd1;
      end
      if (cmd_i.op == OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.action    = act_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.cnt_full  = (cnt_q >= CntW'(TABLE_DEPTH));
  assign sts_o.t_lt_rd   = (t_q < rd_t_q);
  assign sts_o.t_gt_rd   = (t_q > rd_t_q);
  assign sts_o.lo_lt_hi  = (lo_q < hi_q);
  assign sts_o.div1_last = (it_q == 6'(Div1Steps - 1));
  assign sts_o.div2_last = (it_q == 6'(Div2Steps - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `HSI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(TABLE_DEPTH), "sample count above depth")
  `HSI_ASSERT_NXT(a_srch_order, cmd_i.op == OP_SRCH_UPD, lo_q <= hi_q, "search bounds crossed")
  `HSI_ASSERT_NXT(a_seg_dur, cmd_i.op == OP_LAT2, t2_q > t1_q, "segment of zero length")
  `HSI_ASSERT_NXT(a_div1_rem, cmd_i.op == OP_DIV1, rem1_q < {1'b0, dur}, "fraction rem overflow")
  `HSI_ASSERT_IMP(a_push_free, cmd_i.op == OP_PUSH, !out_valid_q || out_ready_i,
    "result pushed over pending output")

endmodule
`default_nettype wire
